// File: rtl/u2g_pkg.sv
// Shared types, constants and glyph tables of the UTF-8 glyph recoder.
`timescale 1ns / 1ps
`default_nettype none

package u2g_pkg;

    // Configuration register indexes
    localparam logic CFG_FORCE_UPPER  = 1'b0;
    localparam logic CFG_DISPLAY_MODE = 1'b1;

    // Display modes; the unused fourth code behaves as graphic
    typedef enum logic [1:0] {
        MODE_GRAPHIC  = 2'd0,
        MODE_CHAR_LCD = 2'd1,
        MODE_TRANSLIT = 2'd2
    } mode_t;

    // Lead bytes
    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] LEAD_C4 = 8'hC4;
    localparam logic [7:0] LEAD_C5 = 8'hC5;
    localparam logic [7:0] LEAD_D0 = 8'hD0;
    localparam logic [7:0] LEAD_D1 = 8'hD1;

    // Cyrillic ranges and offsets
    localparam logic [7:0] YO_TRAIL_D0    = 8'h81;
    localparam logic [7:0] YO_TRAIL_D1    = 8'h91;
    localparam logic [7:0] YO_UPPER_GLYPH = 8'hA8;
    localparam logic [7:0] YO_LOWER_GLYPH = 8'hB8;
    localparam logic [7:0] CYR_D0_LO      = 8'd144;
    localparam logic [7:0] CYR_D0_HI      = 8'd191;
    localparam logic [7:0] CYR_D0_SMALL   = 8'd176;
    localparam logic [7:0] CYR_D1_LO      = 8'd128;
    localparam logic [7:0] CYR_D1_HI      = 8'd143;
    localparam logic [7:0] CYR_D0_SHIFT   = 8'd48;
    localparam logic [7:0] CYR_D1_SHIFT   = 8'd112;
    localparam logic [7:0] CASE_OFFSET    = 8'd32;

    // Control characters remapped on the transliteration LCD
    localparam logic [7:0] CTRL_BELL      = 8'd7;
    localparam logic [7:0] CTRL_TAB       = 8'd9;
    localparam logic [7:0] BELL_GLYPH     = 8'd165;
    localparam logic [7:0] TAB_GLYPH      = 8'd223;
    localparam logic [7:0] TERM_GLYPH     = 8'd0;

    localparam int ACCENT_COUNT = 30;
    localparam int LIST_MAX     = 4;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;

    typedef struct packed {
        logic [15:0] lo_code;
        logic [15:0] up_code;   // zero: no capital form
        logic [7:0]  lo_glyph;
        logic [7:0]  up_glyph;
        logic [7:0]  lo_ascii;
        logic [7:0]  up_ascii;
    } accent_t;

    // Right-aligned text, first letter in the top used byte
    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] text;
    } translit_t;

    // One classified input byte: up to four glyphs and maybe a terminator
    typedef struct packed {
        logic [LIST_MAX-1:0][7:0] glyph;
        logic [2:0]               count;
        logic                     term;
    } q_entry_t;

    localparam accent_t ACCENT_TAB [ACCENT_COUNT] = '{
        '{16'hC485, 16'hC484, 8'h80, 8'h81, "a", "A"},
        '{16'hC487, 16'hC486, 8'h82, 8'h83, "c", "C"},
        '{16'hC499, 16'hC498, 8'h84, 8'h85, "e", "E"},
        '{16'hC582, 16'hC581, 8'h86, 8'h87, "l", "L"},
        '{16'hC584, 16'hC583, 8'h88, 8'h89, "n", "N"},
        '{16'hC3B3, 16'hC393, 8'h8A, 8'h8B, "o", "O"},
        '{16'hC59B, 16'hC59A, 8'h8C, 8'h8D, "s", "S"},
        '{16'hC5BA, 16'hC5B9, 8'h8E, 8'h8F, "z", "Z"},
        '{16'hC5BC, 16'hC5BB, 8'h90, 8'h91, "z", "Z"},
        '{16'hC3A4, 16'hC384, 8'h92, 8'h93, "a", "A"},
        '{16'hC3B6, 16'hC396, 8'h94, 8'h95, "o", "O"},
        '{16'hC3BC, 16'hC39C, 8'h96, 8'h97, "u", "U"},
        '{16'hC39F, 16'h0000, 8'h98, 8'h98, "s", "S"},
        '{16'hC3A9, 16'hC389, 8'h99, 8'h9A, "e", "E"},
        '{16'hC588, 16'hC587, 8'h9B, 8'h9C, "n", "N"},
        '{16'hC595, 16'hC594, 8'h9D, 8'h9E, "r", "R"},
        '{16'hC5A1, 16'hC5A0, 8'h9F, 8'hA0, "s", "S"},
        '{16'hC5A5, 16'hC5A4, 8'hA1, 8'hA2, "t", "T"},
        '{16'hC5BE, 16'hC5BD, 8'hA3, 8'hA4, "z", "Z"},
        '{16'hC5AF, 16'hC5AE, 8'hA5, 8'hA6, "u", "U"},
        '{16'hC48D, 16'hC48C, 8'hA7, 8'hA9, "c", "C"},
        '{16'hC48F, 16'hC48E, 8'hAA, 8'hAB, "d", "D"},
        '{16'hC4BA, 16'hC4B9, 8'hAC, 8'hAD, "l", "L"},
        '{16'hC4BE, 16'hC4BD, 8'hAE, 8'hAF, "l", "L"},
        '{16'hC3A1, 16'hC381, 8'hB0, 8'hB1, "a", "A"},
        '{16'hC3AD, 16'hC38D, 8'hB2, 8'hB3, "i", "I"},
        '{16'hC3B4, 16'hC394, 8'hB4, 8'hB5, "o", "O"},
        '{16'hC3BA, 16'hC39A, 8'hB6, 8'hB7, "u", "U"},
        '{16'hC3BD, 16'hC39D, 8'hB9, 8'hBA, "y", "Y"},
        '{16'hC3A5, 16'hC385, 8'hBB, 8'hBC, "a", "A"}
    };

    // Character LCD ROM codes of capitals U+0410..U+042F
    localparam logic [7:0] ROM_CYR [32] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1
    };

    localparam translit_t TRANSLIT_YO = '{3'd2, "YO"};

    localparam translit_t TRANSLIT [32] = '{
        '{3'd1, "A"},    '{3'd1, "B"},  '{3'd1, "V"},  '{3'd1, "G"},
        '{3'd1, "D"},    '{3'd1, "E"},  '{3'd2, "ZH"}, '{3'd1, "Z"},
        '{3'd1, "I"},    '{3'd1, "Y"},  '{3'd1, "K"},  '{3'd1, "L"},
        '{3'd1, "M"},    '{3'd1, "N"},  '{3'd1, "O"},  '{3'd1, "P"},
        '{3'd1, "R"},    '{3'd1, "S"},  '{3'd1, "T"},  '{3'd1, "U"},
        '{3'd1, "F"},    '{3'd1, "H"},  '{3'd2, "TS"}, '{3'd2, "CH"},
        '{3'd2, "SH"},   '{3'd4, "SHCH"}, '{3'd1, "'"}, '{3'd2, "YU"},
        '{3'd1, "'"},    '{3'd1, "E"},  '{3'd2, "YU"}, '{3'd2, "YA"}
    };

endpackage

`default_nettype wire

// File: rtl/u2g_front.sv
// Front end: configuration, lead tracking, classification and glyph capping.
`timescale 1ns / 1ps
`default_nettype none

module u2g_front #(
    parameter int OUT_CAPACITY = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [1:0]        cfg_data,
    input  wire logic              in_accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              end_of_input,
    output logic                   q_wr,
    output u2g_pkg::q_entry_t      q_wr_data
);

    localparam int CW = (OUT_CAPACITY > 2) ? $clog2(OUT_CAPACITY) : 1;
    localparam int RW = CW + 3;
    localparam logic [CW-1:0] CNT_LIMIT = CW'(OUT_CAPACITY - 1);

    typedef struct packed {
        logic [u2g_pkg::LIST_MAX-1:0][7:0] glyph;
        logic [2:0]                        len;
    } glyph_list_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] glyph;
    } accent_hit_t;

    logic               force_upper_reg;
    logic [1:0]         display_mode_reg;
    logic [7:0]         pend_reg;
    logic [7:0]         pend_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [CW-1:0]      room;
    logic               room_ge2;
    logic               is_full;
    u2g_pkg::mode_t     mode;
    glyph_list_t        lst;
    accent_hit_t        acc;
    logic [2:0]         emit_n;

    function automatic logic [7:0] up_case(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - u2g_pkg::CASE_OFFSET : c;
    endfunction

    function automatic logic [7:0] plain_glyph(input logic [7:0] c,
                                               input u2g_pkg::mode_t m,
                                               input logic fu);
        logic [7:0] ch;
        if (m == u2g_pkg::MODE_TRANSLIT)
        begin
            ch = up_case(c);
            if (ch == u2g_pkg::CTRL_BELL)
                ch = u2g_pkg::BELL_GLYPH;
            else if (ch == u2g_pkg::CTRL_TAB)
                ch = u2g_pkg::TAB_GLYPH;
        end
        else
        begin
            ch = fu ? up_case(c) : c;
        end
        return ch;
    endfunction

    function automatic logic is_lead(input logic [7:0] c);
        return c == u2g_pkg::LEAD_C3 || c == u2g_pkg::LEAD_C4 || c == u2g_pkg::LEAD_C5
            || c == u2g_pkg::LEAD_D0 || c == u2g_pkg::LEAD_D1;
    endfunction

    function automatic glyph_list_t one_glyph(input logic [7:0] g);
        glyph_list_t r;
        r          = '0;
        r.glyph[0] = g;
        r.len      = 3'd1;
        return r;
    endfunction

    function automatic glyph_list_t text_list(input u2g_pkg::translit_t t);
        glyph_list_t r;
        logic [1:0]  pos;
        r     = '0;
        r.len = t.len;
        for (int k = 0; k < u2g_pkg::LIST_MAX; k++)
        begin
            pos = 2'(t.len - 3'(k) - 3'd1);
            if (3'(k) < t.len)
                r.glyph[k] = t.text[{pos, 3'b000} +: 8];
        end
        return r;
    endfunction

    function automatic accent_hit_t accent_match(input logic [7:0] lead,
                                                 input logic [7:0] trail,
                                                 input u2g_pkg::mode_t m,
                                                 input logic fu);
        accent_hit_t r;
        logic        lo;
        logic        up;
        logic        cap;
        r = '0;
        for (int k = 0; k < u2g_pkg::ACCENT_COUNT; k++)
        begin
            lo  = {lead, trail} == u2g_pkg::ACCENT_TAB[k].lo_code;
            up  = u2g_pkg::ACCENT_TAB[k].up_code != 16'h0000
                  && {lead, trail} == u2g_pkg::ACCENT_TAB[k].up_code;
            cap = fu || up;
            if (!r.hit && (lo || up))
            begin
                r.hit = 1'b1;
                if (m == u2g_pkg::MODE_GRAPHIC)
                    r.glyph = cap ? u2g_pkg::ACCENT_TAB[k].up_glyph
                                  : u2g_pkg::ACCENT_TAB[k].lo_glyph;
                else
                    r.glyph = cap ? u2g_pkg::ACCENT_TAB[k].up_ascii
                                  : u2g_pkg::ACCENT_TAB[k].lo_ascii;
            end
        end
        return r;
    endfunction

    function automatic glyph_list_t cyr_list(input logic [7:0] lead,
                                             input logic [7:0] n,
                                             input u2g_pkg::mode_t m,
                                             input logic fu);
        glyph_list_t r;
        logic [7:0]  ch;
        logic [4:0]  idx;
        logic        use_idx;
        r       = '0;
        ch      = '0;
        idx     = '0;
        use_idx = 1'b0;
        if ((lead == u2g_pkg::LEAD_D0 && n == u2g_pkg::YO_TRAIL_D0)
            || (lead == u2g_pkg::LEAD_D1 && n == u2g_pkg::YO_TRAIL_D1))
        begin
            if (m == u2g_pkg::MODE_TRANSLIT)
                r = text_list(u2g_pkg::TRANSLIT_YO);
            else
                r = one_glyph(fu ? u2g_pkg::YO_UPPER_GLYPH : u2g_pkg::YO_LOWER_GLYPH);
        end
        else if (lead == u2g_pkg::LEAD_D0 && n >= u2g_pkg::CYR_D0_LO
                 && n <= u2g_pkg::CYR_D0_HI)
        begin
            if (m == u2g_pkg::MODE_GRAPHIC)
            begin
                ch = n + u2g_pkg::CYR_D0_SHIFT;
                if (n >= u2g_pkg::CYR_D0_SMALL && fu)
                    ch = ch - u2g_pkg::CASE_OFFSET;
                r = one_glyph(ch);
            end
            else
            begin
                use_idx = 1'b1;
                idx = (n >= u2g_pkg::CYR_D0_SMALL) ? 5'(n - u2g_pkg::CYR_D0_SMALL)
                                                   : 5'(n - u2g_pkg::CYR_D0_LO);
            end
        end
        else if (lead == u2g_pkg::LEAD_D1 && n >= u2g_pkg::CYR_D1_LO
                 && n <= u2g_pkg::CYR_D1_HI)
        begin
            if (m == u2g_pkg::MODE_GRAPHIC)
            begin
                ch = n + u2g_pkg::CYR_D1_SHIFT;
                if (fu)
                    ch = ch - u2g_pkg::CASE_OFFSET;
                r = one_glyph(ch);
            end
            else
            begin
                use_idx = 1'b1;
                idx     = {1'b1, n[3:0]};
            end
        end
        if (use_idx)
        begin
            if (m == u2g_pkg::MODE_CHAR_LCD)
                r = one_glyph(u2g_pkg::ROM_CYR[idx]);
            else
                r = text_list(u2g_pkg::TRANSLIT[idx]);
        end
        return r;
    endfunction

    // Fold the unused mode code onto graphic
    always_comb
    begin
        unique case (display_mode_reg)
            u2g_pkg::MODE_CHAR_LCD: mode = u2g_pkg::MODE_CHAR_LCD;
            u2g_pkg::MODE_TRANSLIT: mode = u2g_pkg::MODE_TRANSLIT;
            default:                mode = u2g_pkg::MODE_GRAPHIC;
        endcase
    end

    assign room     = CNT_LIMIT - cnt_reg;
    assign is_full  = room == '0;
    assign room_ge2 = RW'(room) >= RW'(2);
    assign acc      = accent_match(pend_reg, in_byte, mode, force_upper_reg);

    // Classify the byte against the held lead
    always_comb
    begin
        lst       = '0;
        pend_next = pend_reg;
        if (in_byte != 8'h00)
        begin
            if (is_full)
            begin
                pend_next = 8'h00;
            end
            else if (pend_reg != 8'h00)
            begin
                pend_next = 8'h00;
                if (pend_reg == u2g_pkg::LEAD_D0 || pend_reg == u2g_pkg::LEAD_D1)
                begin
                    lst = cyr_list(pend_reg, in_byte, mode, force_upper_reg);
                end
                else if (acc.hit)
                begin
                    lst = one_glyph(acc.glyph);
                end
                else
                begin
                    // unmatched Latin pair: drop the lead out as a plain byte
                    lst = one_glyph(plain_glyph(pend_reg, mode, force_upper_reg));
                    if (room_ge2)
                    begin
                        if (is_lead(in_byte) && !end_of_input)
                        begin
                            pend_next = in_byte;
                        end
                        else
                        begin
                            lst.glyph[1] = plain_glyph(in_byte, mode, force_upper_reg);
                            lst.len      = 3'd2;
                        end
                    end
                end
            end
            else if (is_lead(in_byte) && !end_of_input)
            begin
                pend_next = in_byte;
            end
            else
            begin
                lst = one_glyph(plain_glyph(in_byte, mode, force_upper_reg));
            end
        end
        if (end_of_input)
            pend_next = 8'h00;
    end

    // Cap the glyph count at what the buffer still holds
    always_comb
    begin
        emit_n = (RW'(room) < RW'(lst.len)) ? 3'(room) : lst.len;
        cnt_next = end_of_input ? '0 : cnt_reg + CW'(emit_n);
    end

    always_comb
    begin
        q_wr_data.glyph = lst.glyph;
        q_wr_data.count = emit_n;
        q_wr_data.term  = end_of_input;
        q_wr            = in_accept && (emit_n != 3'd0 || end_of_input);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_upper_reg  <= 1'b0;
            display_mode_reg <= 2'd0;
            pend_reg         <= 8'h00;
            cnt_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    u2g_pkg::CFG_FORCE_UPPER:  force_upper_reg  <= cfg_data[0];
                    u2g_pkg::CFG_DISPLAY_MODE: display_mode_reg <= cfg_data;
                    default:                   force_upper_reg  <= force_upper_reg;
                endcase
            end
            if (in_accept)
            begin
                pend_reg <= pend_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/u2g_queue.sv
// Short job queue between the front end and the glyph serializer.
`timescale 1ns / 1ps
`default_nettype none

module u2g_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire u2g_pkg::q_entry_t wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output logic                   rd_valid,
    output u2g_pkg::q_entry_t      rd_data
);

    u2g_pkg::q_entry_t         slot_reg [u2g_pkg::Q_DEPTH];
    logic [u2g_pkg::Q_AW-1:0]  wr_ptr_reg;
    logic [u2g_pkg::Q_AW-1:0]  rd_ptr_reg;
    logic [u2g_pkg::Q_AW:0]    count_reg;
    logic [u2g_pkg::Q_AW:0]    count_next;
    logic                      wr_fire;
    logic                      rd_fire;

    assign full     = count_reg == (u2g_pkg::Q_AW + 1)'(u2g_pkg::Q_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign wr_fire  = wr_en && !full;
    assign rd_fire  = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (wr_fire && !rd_fire)
            count_next = count_reg + 1'b1;
        else if (!wr_fire && rd_fire)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_fire)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// File: rtl/u2g_back.sv
// Back end: walks each queued job one glyph a beat into the output register.
`timescale 1ns / 1ps
`default_nettype none

module u2g_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire u2g_pkg::q_entry_t q_entry,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             glyph_code,
    output logic                   end_of_output
);

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_glyph_reg;
    logic       out_eoo_reg;
    logic       at_term;
    logic       last_beat;
    logic       load;
    logic [7:0] beat_glyph;

    // A job ends with its terminator if it carries one, else with its last glyph
    assign at_term    = idx_reg == q_entry.count;
    assign last_beat  = at_term || (!q_entry.term && idx_reg == q_entry.count - 3'd1);
    assign beat_glyph = at_term ? u2g_pkg::TERM_GLYPH : q_entry.glyph[idx_reg[1:0]];
    assign load       = q_valid && (!out_valid_reg || pop);
    assign q_pop      = load && last_beat;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last_beat ? 3'd0 : idx_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_glyph_reg <= beat_glyph;
            out_eoo_reg   <= at_term;
        end
    end

    assign empty         = !out_valid_reg;
    assign glyph_code    = out_glyph_reg;
    assign end_of_output = out_eoo_reg;

endmodule

`default_nettype wire

// File: rtl/utf8_to_display_glyph_recoder_unit.sv
// Top level of the UTF-8 to display glyph recoder.
//
//  channel   | signals                                   | beat
//  ----------+-------------------------------------------+------------------------------
//  input     | push, full, in_byte, end_of_input         | push & !full: one string byte
//  result    | empty, pop, glyph_code, end_of_output     | pop & !empty: one glyph/term
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | valid & ready: one reg write
//
// An input byte is classified in the cycle it is accepted and lands in a
// four-entry job queue; the serializer emits one result beat per cycle while
// results are popped. A byte that yields one glyph sustains one byte per cycle
// while pop keeps up; a transliteration of k letters plus an optional terminator
// leaves as k letter beats and a terminator beat, and full rises once the queue holds four jobs.
// Reset (rst_n low, asynchronous) clears config, held lead, glyph count,
// queue and output valid flag; no clearing pass is needed.
// A stalled result holds on the ports; the front keeps taking bytes meanwhile
// until the job queue fills.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_display_glyph_recoder_unit #(
    parameter int OUT_CAPACITY = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // string bytes in
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_input,
    // glyph beats out
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      glyph_code,
    output logic            end_of_output,
    // register writes
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [1:0] cfg_data
);

    logic              in_accept;
    logic              q_wr;
    u2g_pkg::q_entry_t q_wr_data;
    logic              q_valid;
    logic              q_pop;
    u2g_pkg::q_entry_t q_entry;

    // Register writes are always accepted
    assign cfg_ready = 1'b1;
    assign in_accept = push && !full;

    // Front: hold leads, look up tables, cap at the buffer limit
    u2g_front #(
        .OUT_CAPACITY (OUT_CAPACITY)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_accept    (in_accept),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .q_wr         (q_wr),
        .q_wr_data    (q_wr_data)
    );

    // Decouple classification from serialization
    u2g_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (q_wr_data),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_entry)
    );

    // Back: one glyph or terminator per beat into the output register
    u2g_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .glyph_code    (glyph_code),
        .end_of_output (end_of_output)
    );

endmodule

`default_nettype wire

// File: rtl/u2g_checker.sv
// Port-level checker of the glyph recoder and its bind.
`timescale 1ns / 1ps
`default_nettype none

module u2g_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       pop,
    input wire logic       empty,
    input wire logic [7:0] glyph_code,
    input wire logic       end_of_output
);

    // A waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(glyph_code) && $stable(end_of_output)))
        else $error("result changed while stalled");

    // Only the terminator carries a zero glyph
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (end_of_output == (glyph_code == 8'h00)))
        else $error("terminator flag and zero glyph disagree");

    // The queue fills only through an accepted byte
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted byte");

endmodule

bind utf8_to_display_glyph_recoder_unit u2g_checker u_chk (.*);

`default_nettype wire
